@@ src/distinct_prime_factor_range_count_core_macros.svh @@
// Assertion macros used by the checker file.
`ifndef DISTINCT_PRIME_FACTOR_RANGE_COUNT_CORE_MACROS_SVH
`define DISTINCT_PRIME_FACTOR_RANGE_COUNT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DPFC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DPFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dpfc_pkg.sv @@
`timescale 1ns / 1ps

package dpfc_pkg;

  // Default table sizes.
  localparam int LIMIT_DEF       = 65536;
  localparam int MAX_FACTORS_DEF = 10;

  // Fixed field widths.
  localparam int BOUND_W  = 16;
  localparam int FACTOR_W = 4;
  localparam int COUNT_W  = 16;
  localparam int TALLY_W  = 4;

  // One query on the input channel.
  typedef struct packed {
    logic [BOUND_W-1:0]  range_low;
    logic [BOUND_W-1:0]  range_high;
    logic [FACTOR_W-1:0] factor_count;
  } query_t;

  // One answer on the result channel.
  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               bad_query;
  } result_t;

  // Status of the sieve engine toward the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } sieve_stat_t;

endpackage

@@ src/dpfc_sieve.sv @@
`timescale 1ns / 1ps

module dpfc_sieve #(
  parameter int  LIMIT = dpfc_pkg::LIMIT_DEF,
  localparam int IDX_W = $clog2(LIMIT)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output dpfc_pkg::sieve_stat_t         stat,
  input  logic [IDX_W-1:0]              rd_addr,
  output logic [dpfc_pkg::TALLY_W-1:0]  rd_data
);
  import dpfc_pkg::*;

  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_CLR  = 6'b000010,
    S_CHK  = 6'b000100,
    S_CHKD = 6'b001000,
    S_MRD  = 6'b010000,
    S_MWR  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   p_r, p_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   step;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [TALLY_W-1:0] wdata;
  logic [IDX_W-1:0]   raddr;
  logic               done;
  logic [TALLY_W-1:0] tally_mem [LIMIT];
  logic [TALLY_W-1:0] tally_q_r;

  // Sequencer: clear pass, then for each prime bump the tally of every multiple.
  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    we        = 1'b0;
    waddr     = j_r[IDX_W-1:0];
    wdata     = '0;
    raddr     = rd_addr;
    done      = 1'b0;
    step      = j_r + p_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          j_nxt     = '0;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        we = 1'b1;
        if (j_r == LIMIT_C - CNT_W'(1)) begin
          p_nxt     = CNT_W'(2);
          state_nxt = S_CHK;
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
      end
      S_CHK: begin
        if (p_r == LIMIT_C) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          raddr     = p_r[IDX_W-1:0];
          state_nxt = S_CHKD;
        end
      end
      S_CHKD: begin
        // A zero tally here means no smaller prime divides p.
        if (tally_q_r == '0) begin
          j_nxt     = p_r;
          state_nxt = S_MRD;
        end else begin
          p_nxt     = p_r + CNT_W'(1);
          state_nxt = S_CHK;
        end
      end
      S_MRD: begin
        raddr     = j_r[IDX_W-1:0];
        state_nxt = S_MWR;
      end
      S_MWR: begin
        we    = 1'b1;
        wdata = tally_q_r + TALLY_W'(1);
        if (step >= LIMIT_C) begin
          p_nxt     = p_r + CNT_W'(1);
          state_nxt = S_CHK;
        end else begin
          j_nxt     = step;
          state_nxt = S_MRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      j_r     <= j_nxt;
    end
  end

  // Tally memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      tally_mem[waddr] <= wdata;
    end
    tally_q_r <= tally_mem[raddr];
  end

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done;
  assign rd_data   = tally_q_r;

endmodule

@@ src/distinct_prime_factor_range_count_core.sv @@
// Channel  Ports                                   Direction  Payload
// in       in_valid, in_ready, in_payload          to core    query_t
// out      out_valid, out_ready, out_payload       from core  result_t
//
// The first query after reset builds the tables: a pass that clears the
// tally, the sieve over the multiples of every prime, then a fill of the
// prefix rows. Later queries pass through T_EVAL, T_QHI, T_QLO, T_QSUB and
// T_OUT; a malformed or zero-factor query goes from T_EVAL to T_OUT. The two
// prefix reads take turns on the single read port of the prefix memory.
// Reset is synchronous and active low; a result held by a stalled out_ready
// does not block the transfer of the next query.
`timescale 1ns / 1ps

module distinct_prime_factor_range_count_core #(
  parameter int LIMIT       = dpfc_pkg::LIMIT_DEF,
  parameter int MAX_FACTORS = dpfc_pkg::MAX_FACTORS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dpfc_pkg::query_t  in_payload,
  output logic              out_valid,
  input  logic              out_ready,
  output dpfc_pkg::result_t out_payload
);
  import dpfc_pkg::*;

  localparam int IDX_W = $clog2(LIMIT);
  localparam int CNT_W = IDX_W + 1;
  localparam int KW    = (MAX_FACTORS > 1) ? $clog2(MAX_FACTORS) : 1;
  localparam int CW    = (IDX_W > BOUND_W) ? IDX_W : BOUND_W;
  localparam logic [CNT_W-1:0] LIMIT_C = CNT_W'(LIMIT);

  typedef enum logic [7:0] {
    T_IDLE  = 8'b00000001,
    T_SIEVE = 8'b00000010,
    T_FILL  = 8'b00000100,
    T_EVAL  = 8'b00001000,
    T_QHI   = 8'b00010000,
    T_QLO   = 8'b00100000,
    T_QSUB  = 8'b01000000,
    T_OUT   = 8'b10000000
  } state_t;

  state_t             state_r, state_nxt;
  logic               built_r, built_nxt;
  query_t             query_r, query_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               fv_r, fv_nxt;
  logic [IDX_W-1:0]   fa_r, fa_nxt;
  logic [COUNT_W-1:0] run_r, run_nxt;
  logic [COUNT_W-1:0] hi_val_r, hi_val_nxt;
  result_t            res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_payload_r, out_payload_nxt;

  logic               sieve_start;
  sieve_stat_t        sieve_stat;
  logic [IDX_W-1:0]   tally_raddr;
  logic [TALLY_W-1:0] tally_q;
  logic               hit;
  logic               qbad;

  logic               pfx_we;
  logic [COUNT_W-1:0] pfx_wdata;
  logic               pfx_re;
  logic [KW-1:0]      pfx_rrow;
  logic [IDX_W-1:0]   pfx_raddr;
  logic [COUNT_W-1:0] pfx_mem [MAX_FACTORS][LIMIT];
  logic [COUNT_W-1:0] pfx_q_r;

  // Bounds above the table end count as the last table index.
  function automatic logic [IDX_W-1:0] clamp_idx(input logic [BOUND_W-1:0] v);
    logic [CW-1:0] ve;
    ve = CW'(v);
    if (ve > CW'(LIMIT - 1)) begin
      return IDX_W'(LIMIT - 1);
    end
    return IDX_W'(ve);
  endfunction

  dpfc_sieve #(
    .LIMIT(LIMIT)
  ) u_sieve (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sieve_start),
    .stat    (sieve_stat),
    .rd_addr (tally_raddr),
    .rd_data (tally_q)
  );

  // Query checks and the prefix-row hit test.
  assign qbad = (query_r.factor_count > FACTOR_W'(MAX_FACTORS)) ||
                (query_r.range_low > query_r.range_high) ||
                (query_r.range_low == '0);
  assign hit  = (tally_q == (TALLY_W'(k_r) + TALLY_W'(1)));
  assign pfx_wdata = run_r + COUNT_W'(hit);
  assign pfx_rrow  = KW'(query_r.factor_count - FACTOR_W'(1));

  // Controller: build once; valid queries with factors use two prefix reads.
  always_comb begin
    state_nxt       = state_r;
    built_nxt       = built_r;
    query_nxt       = query_r;
    k_nxt           = k_r;
    j_nxt           = j_r;
    fv_nxt          = fv_r;
    fa_nxt          = fa_r;
    run_nxt         = run_r;
    hi_val_nxt      = hi_val_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_payload_nxt = out_payload_r;
    sieve_start     = 1'b0;
    tally_raddr     = j_r[IDX_W-1:0];
    pfx_we          = 1'b0;
    pfx_re          = 1'b0;
    pfx_raddr       = clamp_idx(query_r.range_high);
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) begin
          query_nxt = in_payload;
          if (built_r) begin
            state_nxt = T_EVAL;
          end else begin
            sieve_start = 1'b1;
            state_nxt   = T_SIEVE;
          end
        end
      end
      T_SIEVE: begin
        if (sieve_stat.done) begin
          k_nxt     = '0;
          j_nxt     = '0;
          fv_nxt    = 1'b0;
          run_nxt   = '0;
          state_nxt = T_FILL;
        end
      end
      T_FILL: begin
        // Stream one tally read per cycle; its write comes in the next cycle.
        if (j_r != LIMIT_C) begin
          j_nxt  = j_r + CNT_W'(1);
          fv_nxt = 1'b1;
          fa_nxt = j_r[IDX_W-1:0];
        end else begin
          fv_nxt = 1'b0;
        end
        if (fv_r) begin
          pfx_we  = 1'b1;
          run_nxt = pfx_wdata;
        end
        if (!fv_r && (j_r == LIMIT_C)) begin
          if (k_r == KW'(MAX_FACTORS - 1)) begin
            built_nxt = 1'b1;
            state_nxt = T_EVAL;
          end else begin
            k_nxt   = k_r + KW'(1);
            j_nxt   = '0;
            run_nxt = '0;
          end
        end
      end
      T_EVAL: begin
        if (qbad) begin
          res_nxt.match_count = '0;
          res_nxt.bad_query   = 1'b1;
          state_nxt           = T_OUT;
        end else if (query_r.factor_count == '0) begin
          res_nxt.match_count = COUNT_W'(query_r.range_low == BOUND_W'(1));
          res_nxt.bad_query   = 1'b0;
          state_nxt           = T_OUT;
        end else begin
          state_nxt = T_QHI;
        end
      end
      T_QHI: begin
        pfx_re    = 1'b1;
        state_nxt = T_QLO;
      end
      T_QLO: begin
        pfx_re     = 1'b1;
        pfx_raddr  = clamp_idx(query_r.range_low - BOUND_W'(1));
        hi_val_nxt = pfx_q_r;
        state_nxt  = T_QSUB;
      end
      T_QSUB: begin
        res_nxt.match_count = hi_val_r - pfx_q_r;
        res_nxt.bad_query   = 1'b0;
        state_nxt           = T_OUT;
      end
      T_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_payload_nxt = res_r;
          state_nxt       = T_IDLE;
        end
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      built_r     <= 1'b0;
      fv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      built_r     <= built_nxt;
      fv_r        <= fv_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    query_r       <= query_nxt;
    fa_r          <= fa_nxt;
    run_r         <= run_nxt;
    hi_val_r      <= hi_val_nxt;
    res_r         <= res_nxt;
    out_payload_r <= out_payload_nxt;
  end

  // Prefix-count memory: one row per factor count, registered read.
  always_ff @(posedge clk) begin
    if (pfx_we) begin
      pfx_mem[k_r][fa_r] <= pfx_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (pfx_re) begin
      pfx_q_r <= pfx_mem[pfx_rrow][pfx_raddr];
    end
  end

  assign in_ready    = (state_r == T_IDLE);
  assign out_valid   = out_valid_r;
  assign out_payload = out_payload_r;

endmodule

@@ src/dpfc_checker.sv @@
`timescale 1ns / 1ps
`include "distinct_prime_factor_range_count_core_macros.svh"

module dpfc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input dpfc_pkg::query_t  in_payload,
  input logic              out_valid,
  input logic              out_ready,
  input dpfc_pkg::result_t out_payload
);
  import dpfc_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending_r;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Queries taken whose answers have not been transferred yet.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  // A stalled query keeps its payload.
  `DPFC_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_payload), "query dropped or changed while stalled")

  // A stalled result keeps its payload.
  `DPFC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload), "result dropped or changed while stalled")

  // A malformed query never reports a count.
  `DPFC_ASSERT_SAME(a_bad_zero, clk, rst_n, out_valid && out_payload.bad_query, out_payload.match_count == '0, "bad query with nonzero count")

  // Every result answers a query that was taken.
  `DPFC_ASSERT_SAME(a_no_extra, clk, rst_n, out_xfer, pending_r != 2'd0, "result without a pending query")

  // The core is busy in the cycle after it takes a query.
  `DPFC_ASSERT_NEXT(a_busy_after, clk, rst_n, in_xfer, !in_ready, "ready right after a query transfer")

endmodule

bind distinct_prime_factor_range_count_core dpfc_checker u_dpfc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .in_payload  (in_payload),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_payload (out_payload)
);

@@ tb/tb_distinct_prime_factor_range_count_core.sv @@
`timescale 1ns / 1ps

module tb_distinct_prime_factor_range_count_core;
  import dpfc_pkg::*;

  localparam int TABLE_SIZE    = LIMIT_DEF;
  localparam int MAX_K         = MAX_FACTORS_DEF;
  localparam int TOTAL_QUERIES = 1550;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLDOFF_LEN   = 400;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_ready;
  query_t  in_payload = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  result_t out_payload;

  // Independent sieve tables used to predict every answer.
  bit [TALLY_W-1:0] factor_tally [TABLE_SIZE];
  int unsigned      count_upto [MAX_K][TABLE_SIZE];

  query_t      pending_queries[$];
  result_t     expected_results[$];
  result_t     expected_result;
  int unsigned queries_sent = 0;
  int unsigned queries_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned sender_idle_pct = 12;
  int unsigned receiver_idle_pct = 60;
  logic        hold_queries = 1'b0;
  logic        hold_results = 1'b0;

  distinct_prime_factor_range_count_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_payload (in_payload),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_payload(out_payload)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Answer for one query, read from the prefix counts.
  function automatic result_t count_in_range(query_t q);
    result_t     r;
    int unsigned hi_idx;
    int unsigned lo_idx;
    r.match_count = '0;
    r.bad_query   = 1'b0;
    if (q.factor_count > MAX_K || q.range_low > q.range_high || q.range_low == 0) begin
      r.bad_query = 1'b1;
    end else if (q.factor_count == 0) begin
      r.match_count = (q.range_low == 1) ? COUNT_W'(1) : '0;
    end else begin
      hi_idx = (q.range_high < TABLE_SIZE) ? q.range_high : TABLE_SIZE - 1;
      lo_idx = (q.range_low - 1 < TABLE_SIZE) ? q.range_low - 1 : TABLE_SIZE - 1;
      r.match_count = COUNT_W'(count_upto[q.factor_count - 1][hi_idx]
                               - count_upto[q.factor_count - 1][lo_idx]);
    end
    return r;
  endfunction

  // Append one query to the stimulus list.
  function automatic void queue_query(query_t q);
    pending_queries = {pending_queries, q};
  endfunction

  // Append one predicted answer to the scoreboard.
  function automatic void queue_expected(result_t r);
    expected_results = {expected_results, r};
  endfunction

  // Query driver: a new query goes up only after the previous transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && queries_accepted != queries_sent) begin
      in_valid <= 1'b1;
    end else if (hold_queries || pending_queries.size() == 0 ||
                 $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
    end else begin
      in_payload   <= pending_queries.pop_front();
      in_valid     <= 1'b1;
      queries_sent <= queries_sent + 1;
    end
  end

  // Result receiver with random backpressure and a forced hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_results) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Monitor: check result transfers, then record newly accepted queries.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) begin
            $display("unexpected result: count %0d bad %0b",
                     out_payload.match_count, out_payload.bad_query);
          end
        end else begin
          expected_result = expected_results.pop_front();
          if (out_payload.match_count !== expected_result.match_count ||
              out_payload.bad_query !== expected_result.bad_query) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) begin
              $display("result mismatch: expected count %0d bad %0b, got count %0d bad %0b",
                       expected_result.match_count, expected_result.bad_query,
                       out_payload.match_count, out_payload.bad_query);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        queue_expected(count_in_range(in_payload));
        queries_accepted <= queries_accepted + 1;
      end
    end
  end

  // Long receiver hold-off so the core fills up and stalls its input.
  initial begin
    while (queries_accepted < 300) @(negedge clk);
    hold_results <= 1'b1;
    repeat (HOLDOFF_LEN) @(negedge clk);
    hold_results <= 1'b0;
  end

  // Hard stop in case the core hangs.
  initial begin
    #80_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Tables, stimulus, idling phases and end of run.
  initial begin
    query_t      q;
    int unsigned pick;
    int unsigned span;

    // Sieve: every prime bumps the tally of each of its multiples.
    for (int n = 0; n < TABLE_SIZE; n++) factor_tally[n] = '0;
    for (int p = 2; p < TABLE_SIZE; p++) begin
      if (factor_tally[p] == 0) begin
        for (int m = p; m < TABLE_SIZE; m += p) factor_tally[m] = factor_tally[m] + 1'b1;
      end
    end
    for (int k = 0; k < MAX_K; k++) begin
      count_upto[k][0] = 0;
      for (int n = 1; n < TABLE_SIZE; n++) begin
        count_upto[k][n] = count_upto[k][n - 1] + ((factor_tally[n] == k + 1) ? 1 : 0);
      end
    end

    // Directed queries: zero factors, malformed queries and the extremes.
    queue_query(query_t'{16'd1, 16'd1, 4'd0});
    queue_query(query_t'{16'd2, 16'd10, 4'd0});
    queue_query(query_t'{16'd1, 16'd65535, 4'd0});
    queue_query(query_t'{16'd0, 16'd5, 4'd1});
    queue_query(query_t'{16'd0, 16'd0, 4'd0});
    queue_query(query_t'{16'd5, 16'd4, 4'd1});
    queue_query(query_t'{16'd65535, 16'd0, 4'd10});
    queue_query(query_t'{16'd1, 16'd100, 4'd11});
    queue_query(query_t'{16'd1, 16'd100, 4'd15});
    queue_query(query_t'{16'd1, 16'd1, 4'd1});
    queue_query(query_t'{16'd2, 16'd2, 4'd1});
    queue_query(query_t'{16'd65535, 16'd65535, 4'd4});
    queue_query(query_t'{16'd30030, 16'd30030, 4'd6});
    for (int k = 1; k <= MAX_K; k++) begin
      queue_query(query_t'{16'd1, 16'd65535, FACTOR_W'(k)});
    end

    // Random queries: mostly well formed, the rest malformed or pure noise.
    while (pending_queries.size() < TOTAL_QUERIES) begin
      pick = $urandom_range(99);
      q.factor_count = FACTOR_W'($urandom_range(MAX_K));
      if (pick < 30) q.range_low = BOUND_W'($urandom_range(300, 1));
      else if (pick < 50) q.range_low = BOUND_W'($urandom_range(65535, 65000));
      else q.range_low = BOUND_W'($urandom_range(65535, 1));
      span = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(64);
      q.range_high = (q.range_low + span > 65535) ? 16'hFFFF : BOUND_W'(q.range_low + span);
      if (pick >= 85) begin
        case (pick % 4)
          0: q.factor_count = FACTOR_W'($urandom_range(15, MAX_K + 1));
          1: q.range_low = '0;
          2: q.range_high = BOUND_W'($urandom_range(q.range_low - 1));
          default: begin
            q.range_low    = BOUND_W'($urandom);
            q.range_high   = BOUND_W'($urandom);
            q.factor_count = FACTOR_W'($urandom);
          end
        endcase
      end
      queue_query(q);
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Swap the idling pattern, then run with no idling at all.
    while (queries_accepted < 500) @(negedge clk);
    sender_idle_pct   <= 60;
    receiver_idle_pct <= 12;
    while (queries_accepted < 1000) @(negedge clk);
    sender_idle_pct   <= 0;
    receiver_idle_pct <= 0;

    // Sender pause until every outstanding result has come back.
    while (queries_accepted < 1200) @(negedge clk);
    hold_queries <= 1'b1;
    @(negedge clk);
    while (queries_accepted != queries_sent || expected_results.size() != 0) @(negedge clk);
    hold_queries <= 1'b0;

    while (queries_accepted < TOTAL_QUERIES || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/dpfc_pkg.sv
src/dpfc_sieve.sv
src/distinct_prime_factor_range_count_core.sv
src/dpfc_checker.sv
tb/tb_distinct_prime_factor_range_count_core.sv
